/* hw/rtl/spc_pkg.sv */
// Shared types, widths and constants for the servo PID position controller.
package spc_pkg;

    // Field widths fixed by the interface.
    localparam int POS_W     = 10;
    localparam int GAIN_W    = 10;
    localparam int DB_W      = 9;
    localparam int CNT_W     = 8;
    localparam int DRIVE_W   = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;

    // Internal arithmetic widths.
    localparam int ERR_W  = POS_W + 1;          // error is zero or negative
    localparam int ES_W   = 32;                 // integral accumulator
    localparam int PID_W  = 44;                 // sum of the three products
    localparam int THR_W  = 18;                 // saturation threshold on the sum
    localparam int M_W    = 17;                 // clipped magnitude fed to the divider
    localparam int RECIP_W = 19;
    localparam int PROD_W = M_W + RECIP_W;
    localparam int Q_W    = 11;
    localparam int LVL_W  = 13;

    localparam logic [DRIVE_W-1:0] DRIVE_MAX = 10'd1023;

    // Division by 100 as a multiply by ceil(2^25 / 100) and a shift. It is
    // exact for magnitudes below 493447; larger ones are clipped first, which
    // does not change the clamped drive level.
    localparam logic [RECIP_W-1:0] RECIP_100   = 19'd335545;
    localparam int                 RECIP_SHIFT = 25;
    localparam logic [M_W-1:0]     M_CLAMP     = 17'd131071;

    localparam logic [CNT_W-1:0] COUNT_RESET = 8'd6;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_BRAKE = 2'd2,
        MODE_STOP  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        DRV_HOLD = 2'd0,
        DRV_LOAD = 2'd1,
        DRV_ZERO = 2'd2
    } t_drv_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P       = 3'd0,
        CFG_GAIN_I       = 3'd1,
        CFG_GAIN_D       = 3'd2,
        CFG_SLEW_STEP    = 3'd3,
        CFG_DEAD_BAND    = 3'd4,
        CFG_DRIVE_FLOOR  = 3'd5,
        CFG_SETTLE_TICKS = 3'd6,
        CFG_SERVO_ON     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        [GAIN_W-1:0]  gain_p;
        logic        [GAIN_W-1:0]  gain_i;
        logic        [GAIN_W-1:0]  gain_d;
        logic        [POS_W-1:0]   slew_step;
        logic        [DB_W-1:0]    dead_band;
        logic        [DRIVE_W-1:0] drive_floor;
        logic        [CNT_W-1:0]   settle_ticks;
        logic                      servo_on;
        logic signed [THR_W-1:0]   sat_thresh;
    } t_cfg;

    // Handoff from the state pass to the drive stage.
    typedef struct packed {
        logic signed [PID_W-1:0] pid;
        t_drv_op                 drv_op;
        t_mode                   mode;
        logic                    dir;
        logic                    sat;
        logic                    on;
    } t_stage;

    // The drive saturates when floor - trunc(pid / 100) > DRIVE_MAX, which is
    // the same as pid <= 100 * (floor - DRIVE_MAX - 1).
    function automatic logic signed [THR_W-1:0] sat_thresh(input logic [DRIVE_W-1:0] floor_lvl);
        logic signed [THR_W-1:0] d;
        begin
            d = {{(THR_W-DRIVE_W){1'b0}}, floor_lvl}
                - {{(THR_W-DRIVE_W){1'b0}}, DRIVE_MAX} - THR_W'(1);
            sat_thresh = (d <<< 6) + (d <<< 5) + (d <<< 2);
        end
    endfunction

endpackage

/* hw/rtl/servo_pid_position_controller.sv */
// Top level of the servo PID position controller: ports, configuration and pipeline control.
//
//   Channel   Direction  Handshake                  Carries
//   -------   ---------  -------------------------  -----------------------------------------
//   input     in         i_valid / o_stall          i_target_pos, i_measured_pos
//   result    out        o_valid / i_stall          o_fwd_drive, o_rev_drive, o_loop_mode,
//                                                   o_turn_dir, o_drive_saturated
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_wdata
//
// The block takes one item per clock cycle while o_stall is low; each item passes through
// an input register, the state pass and the drive stage.
// The state pass closes the tick-to-tick loop (integral and saturation flag) on its own;
// saturation is found by comparing the PID sum against a threshold, so the division by
// 100 sits in the following drive stage, outside the loop.
// Reset is synchronous and active low. It loads the default configuration, puts the mode
// machine in start and empties the pipeline; no clearing pass is needed.
// A stall on the result side holds the output register; stages behind it keep filling,
// and o_stall rises only once all three stages hold an item.
module servo_pid_position_controller import spc_pkg::*; #(
    parameter int HISTORY_DEPTH = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [POS_W-1:0]     i_target_pos,
    input  logic [POS_W-1:0]     i_measured_pos,

    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DRIVE_W-1:0]   o_fwd_drive,
    output logic [DRIVE_W-1:0]   o_rev_drive,
    output logic [1:0]           o_loop_mode,
    output logic                 o_turn_dir,
    output logic                 o_drive_saturated,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata
);

    t_cfg               r_cfg;

    logic               r_in_valid;
    logic [POS_W-1:0]   r_target_pos;
    logic [POS_W-1:0]   r_measured_pos;
    logic               r_s1_valid;
    logic               r_out_valid;

    logic               en_in;
    logic               en_s1;
    logic               en_out;
    logic               fire_s1;
    logic               fire_out;

    t_stage             stage;
    t_mode              out_mode;

    // Configuration registers. Writes are always taken; the data is cut to
    // the width of the register addressed.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p       <= 10'd100;
            r_cfg.gain_i       <= 10'd1;
            r_cfg.gain_d       <= 10'd100;
            r_cfg.slew_step    <= 10'd20;
            r_cfg.dead_band    <= 9'd10;
            r_cfg.drive_floor  <= 10'd75;
            r_cfg.settle_ticks <= COUNT_RESET;
            r_cfg.servo_on     <= 1'b1;
            r_cfg.sat_thresh   <= sat_thresh(10'd75);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GAIN_P:       r_cfg.gain_p       <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_I:       r_cfg.gain_i       <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D:       r_cfg.gain_d       <= i_cfg_wdata[GAIN_W-1:0];
                CFG_SLEW_STEP:    r_cfg.slew_step    <= i_cfg_wdata[POS_W-1:0];
                CFG_DEAD_BAND:    r_cfg.dead_band    <= i_cfg_wdata[DB_W-1:0];
                CFG_DRIVE_FLOOR: begin
                    r_cfg.drive_floor <= i_cfg_wdata[DRIVE_W-1:0];
                    r_cfg.sat_thresh  <= sat_thresh(i_cfg_wdata[DRIVE_W-1:0]);
                end
                CFG_SETTLE_TICKS: r_cfg.settle_ticks <= i_cfg_wdata[CNT_W-1:0];
                CFG_SERVO_ON:     r_cfg.servo_on     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Each stage moves on when the stage after it is empty or moving.
    assign en_out   = !r_out_valid || !i_stall;
    assign en_s1    = !r_s1_valid || en_out;
    assign en_in    = !r_in_valid || en_s1;
    assign fire_s1  = r_in_valid && en_s1;
    assign fire_out = r_s1_valid && en_out;
    assign o_stall  = !en_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_in) begin
                r_in_valid <= i_valid;
            end
            if (en_s1) begin
                r_s1_valid <= r_in_valid;
            end
            if (en_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && en_in) begin
            r_target_pos   <= i_target_pos;
            r_measured_pos <= i_measured_pos;
        end
    end

    // The state pass updates the controller state once per item, in order.
    spc_state #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_state (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire_s1),
        .i_target_pos   (r_target_pos),
        .i_measured_pos (r_measured_pos),
        .i_cfg          (r_cfg),
        .o_stage        (stage)
    );

    // The drive stage keeps the held drive level and forms the result item.
    spc_drive u_drive (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire_out),
        .i_stage       (stage),
        .i_drive_floor (r_cfg.drive_floor),
        .o_fwd_drive   (o_fwd_drive),
        .o_rev_drive   (o_rev_drive),
        .o_mode        (out_mode),
        .o_dir         (o_turn_dir),
        .o_sat         (o_drive_saturated)
    );

    assign o_valid     = r_out_valid;
    assign o_loop_mode = out_mode;

    // Outside brake the motor is never driven both ways at once.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_loop_mode != MODE_BRAKE) |-> (o_fwd_drive == '0 || o_rev_drive == '0))
        else $error("drive on both sides outside brake");

    // An enabled brake result carries full drive on both sides.
    a_brake_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cfg.servo_on && o_loop_mode == MODE_BRAKE)
        |-> (o_fwd_drive == DRIVE_MAX && o_rev_drive == DRIVE_MAX))
        else $error("brake result without full drive");

    // Input is held off only when every stage holds an item.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_s1_valid && r_out_valid))
        else $error("input stalled with an empty stage");

    // An item leaving the state pass is shown as a result on the next cycle.
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire_out |=> o_valid)
        else $error("result lost between stages");

endmodule

/* hw/rtl/spc_state.sv */
// State pass: mode machine, slew limit, error history, integral and PID sum.
module spc_state import spc_pkg::*; #(
    parameter int HISTORY_DEPTH = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [POS_W-1:0]   i_target_pos,
    input  logic [POS_W-1:0]   i_measured_pos,
    input  t_cfg               i_cfg,
    output t_stage             o_stage
);

    localparam int TAPS = HISTORY_DEPTH - 1;
    localparam int PP_W = GAIN_W + 1 + ERR_W;
    localparam int PI_W = GAIN_W + 1 + ES_W;
    localparam int DF_W = ERR_W + 1;
    localparam int PD_W = GAIN_W + 1 + DF_W;

    t_mode                   r_mode, n_mode;
    logic                    r_dir_now, n_dir_now;
    logic                    r_dir_before, n_dir_before;
    logic                    r_sat, n_sat;
    logic [CNT_W-1:0]        r_stop_cnt, n_stop_cnt;
    logic [CNT_W-1:0]        r_brake_cnt, n_brake_cnt;
    logic [POS_W-1:0]        r_cmd, n_cmd;
    logic signed [ES_W-1:0]  r_es, n_es;
    logic signed [ERR_W-1:0] r_hist [TAPS];
    logic                    n_hist_shift;
    t_stage                  r_stage, n_stage;

    logic [POS_W-1:0]        pos_dist;
    logic                    do_run;
    logic [CNT_W-1:0]        bc_run;
    logic [POS_W:0]          cmd_up;
    logic [POS_W-1:0]        cmd_dn;
    logic [POS_W-1:0]        cmd_new;
    logic signed [ERR_W-1:0] err;
    logic                    dir_run;
    logic signed [ERR_W-1:0] past;
    logic signed [ES_W-1:0]  es_base;
    logic signed [ES_W:0]    acc;
    logic signed [ES_W-1:0]  es_run;
    logic signed [DF_W-1:0]  diff;
    logic signed [PP_W-1:0]  p_p;
    logic signed [PI_W-1:0]  p_i;
    logic signed [PD_W-1:0]  p_d;
    logic signed [PID_W-1:0] pid;
    logic                    sat_run;

    assign pos_dist = (i_measured_pos > i_target_pos) ? i_measured_pos - i_target_pos
                                                      : i_target_pos - i_measured_pos;

    // Run step, evaluated every cycle and used when the mode machine asks for it.
    always_comb begin
        if (pos_dist < {1'b0, i_cfg.dead_band}) begin
            bc_run = (r_brake_cnt != '0) ? r_brake_cnt - CNT_W'(1) : r_brake_cnt;
        end else begin
            bc_run = i_cfg.settle_ticks;
        end

        cmd_up = {1'b0, r_cmd} + {1'b0, i_cfg.slew_step};
        cmd_dn = r_cmd - i_cfg.slew_step;
        if (r_cmd < i_target_pos) begin
            cmd_new = (cmd_up > {1'b0, i_target_pos}) ? i_target_pos : cmd_up[POS_W-1:0];
        end else if (r_cmd > i_target_pos) begin
            cmd_new = (r_cmd < i_cfg.slew_step || cmd_dn < i_target_pos) ? i_target_pos
                                                                         : cmd_dn;
        end else begin
            cmd_new = r_cmd;
        end

        if (i_measured_pos < cmd_new) begin
            dir_run = 1'b0;
            err     = {1'b0, i_measured_pos} - {1'b0, cmd_new};
        end else if (i_measured_pos > cmd_new) begin
            dir_run = 1'b1;
            err     = {1'b0, cmd_new} - {1'b0, i_measured_pos};
        end else begin
            dir_run = r_dir_now;
            err     = '0;
        end

        past    = r_hist[TAPS-1];
        es_base = (r_dir_before != dir_run) ? '0 : r_es;
        acc     = {es_base[ES_W-1], es_base} + (ES_W+1)'(err);
        if (r_sat) begin
            es_run = es_base;
        end else if (acc[ES_W] != acc[ES_W-1]) begin
            es_run = {1'b1, {(ES_W-1){1'b0}}};
        end else begin
            es_run = acc[ES_W-1:0];
        end

        diff    = DF_W'(err) - DF_W'(past);
        p_p     = PP_W'($signed({1'b0, i_cfg.gain_p})) * PP_W'(err);
        p_i     = PI_W'($signed({1'b0, i_cfg.gain_i})) * PI_W'(es_run);
        p_d     = PD_W'($signed({1'b0, i_cfg.gain_d})) * PD_W'(diff);
        pid     = PID_W'(p_p) + PID_W'(p_i) + PID_W'(p_d);
        sat_run = (pid <= PID_W'(i_cfg.sat_thresh));
    end

    // Mode machine.
    always_comb begin
        n_mode       = r_mode;
        n_dir_now    = r_dir_now;
        n_dir_before = r_dir_before;
        n_sat        = r_sat;
        n_stop_cnt   = r_stop_cnt;
        n_brake_cnt  = r_brake_cnt;
        n_cmd        = r_cmd;
        n_es         = r_es;
        n_hist_shift = 1'b0;
        do_run       = 1'b0;
        n_stage.drv_op = DRV_HOLD;

        if (i_cfg.servo_on) begin
            unique case (r_mode)
                MODE_START: begin
                    n_dir_now = (i_target_pos < i_measured_pos) ? 1'b0 : 1'b1;
                    n_mode    = MODE_RUN;
                    n_es      = '0;
                    n_cmd     = i_measured_pos;
                end
                MODE_BRAKE: begin
                    if (pos_dist > {i_cfg.dead_band, 1'b0}) begin
                        n_stop_cnt = i_cfg.settle_ticks;
                        n_mode     = MODE_RUN;
                        do_run     = 1'b1;
                    end else if (r_stop_cnt != '0) begin
                        n_stop_cnt = r_stop_cnt - CNT_W'(1);
                    end else begin
                        n_stage.drv_op = DRV_ZERO;
                        n_es           = '0;
                        n_mode         = MODE_STOP;
                    end
                end
                MODE_RUN: begin
                    do_run = 1'b1;
                end
                MODE_STOP: begin
                    if (pos_dist > {1'b0, i_cfg.dead_band}) begin
                        n_mode = MODE_RUN;
                    end else begin
                        n_stage.drv_op = DRV_ZERO;
                    end
                    n_cmd = i_measured_pos;
                end
                default: begin
                    n_mode = MODE_START;
                end
            endcase

            if (do_run) begin
                n_brake_cnt = bc_run;
                if (bc_run == '0) begin
                    n_mode = MODE_BRAKE;
                end else begin
                    n_stop_cnt     = i_cfg.settle_ticks;
                    n_cmd          = cmd_new;
                    n_dir_now      = dir_run;
                    n_dir_before   = dir_run;
                    n_es           = es_run;
                    n_sat          = sat_run;
                    n_hist_shift   = 1'b1;
                    n_stage.drv_op = DRV_LOAD;
                end
            end
        end

        n_stage.pid  = pid;
        n_stage.mode = n_mode;
        n_stage.dir  = n_dir_now;
        n_stage.sat  = n_sat;
        n_stage.on   = i_cfg.servo_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_START;
            r_dir_now    <= 1'b0;
            r_dir_before <= 1'b0;
            r_sat        <= 1'b0;
            r_stop_cnt   <= COUNT_RESET;
            r_brake_cnt  <= COUNT_RESET;
            r_cmd        <= '0;
            r_es         <= '0;
            for (int k = 0; k < TAPS; k++) begin
                r_hist[k] <= '0;
            end
        end else if (i_fire) begin
            r_mode       <= n_mode;
            r_dir_now    <= n_dir_now;
            r_dir_before <= n_dir_before;
            r_sat        <= n_sat;
            r_stop_cnt   <= n_stop_cnt;
            r_brake_cnt  <= n_brake_cnt;
            r_cmd        <= n_cmd;
            r_es         <= n_es;
            if (n_hist_shift) begin
                r_hist[0] <= err;
                for (int k = 1; k < TAPS; k++) begin
                    r_hist[k] <= r_hist[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

/* hw/rtl/spc_drive.sv */
// Drive stage: divides the PID sum by 100, clamps the level and forms the result.
module spc_drive import spc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  t_stage             i_stage,
    input  logic [DRIVE_W-1:0] i_drive_floor,
    output logic [DRIVE_W-1:0] o_fwd_drive,
    output logic [DRIVE_W-1:0] o_rev_drive,
    output t_mode              o_mode,
    output logic               o_dir,
    output logic               o_sat
);

    logic [DRIVE_W-1:0]      r_level, n_level;
    logic [DRIVE_W-1:0]      r_fwd, n_fwd;
    logic [DRIVE_W-1:0]      r_rev, n_rev;
    t_mode                   r_mode;
    logic                    r_dir;
    logic                    r_sat;

    logic [PID_W-1:0]        mag;
    logic [M_W-1:0]          m_clip;
    logic [PROD_W-1:0]       prod;
    logic [Q_W-1:0]          quot;
    logic signed [LVL_W-1:0] lvl;
    logic [DRIVE_W-1:0]      lvl_clamped;

    always_comb begin
        mag    = i_stage.pid[PID_W-1] ? PID_W'(-i_stage.pid) : PID_W'(i_stage.pid);
        m_clip = (mag > PID_W'(M_CLAMP)) ? M_CLAMP : mag[M_W-1:0];
        prod   = PROD_W'(m_clip) * PROD_W'(RECIP_100);
        quot   = prod[RECIP_SHIFT +: Q_W];

        // The quotient truncates toward zero, so its sign follows the sum.
        if (i_stage.pid[PID_W-1]) begin
            lvl = LVL_W'(i_drive_floor) + LVL_W'(quot);
        end else begin
            lvl = LVL_W'(i_drive_floor) - LVL_W'(quot);
        end

        if (lvl < 0) begin
            lvl_clamped = '0;
        end else if (lvl > LVL_W'(DRIVE_MAX)) begin
            lvl_clamped = DRIVE_MAX;
        end else begin
            lvl_clamped = lvl[DRIVE_W-1:0];
        end

        case (i_stage.drv_op)
            DRV_LOAD: n_level = lvl_clamped;
            DRV_ZERO: n_level = '0;
            default:  n_level = r_level;
        endcase

        n_fwd = '0;
        n_rev = '0;
        if (i_stage.on) begin
            if (i_stage.mode == MODE_BRAKE) begin
                n_fwd = DRIVE_MAX;
                n_rev = DRIVE_MAX;
            end else if (i_stage.mode == MODE_RUN) begin
                if (i_stage.dir) begin
                    n_rev = n_level;
                end else begin
                    n_fwd = n_level;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_fire) begin
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_fwd  <= n_fwd;
            r_rev  <= n_rev;
            r_mode <= i_stage.mode;
            r_dir  <= i_stage.dir;
            r_sat  <= i_stage.sat;
        end
    end

    assign o_fwd_drive = r_fwd;
    assign o_rev_drive = r_rev;
    assign o_mode      = r_mode;
    assign o_dir       = r_dir;
    assign o_sat       = r_sat;

endmodule

/* test/servo_pid_position_controller_tb.sv */
// Self-checking testbench for the servo PID position controller: predicted drive per tick.
module servo_pid_position_controller_tb import spc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // The predictor's ring of past errors has this many entries, the block's HISTORY_DEPTH.
    localparam int HIST_DEPTH = 6;
    // The run is stopped as a failure when this many clock cycles have passed.
    localparam int CYCLE_LIMIT = 400000;
    // The integral saturates at the most negative 32-bit value.
    localparam longint SUM_FLOOR = -64'sd2147483648;

    // One copy of every configuration register, at the widths of the block.
    typedef struct {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [POS_W-1:0]   slew_step;
        logic [DB_W-1:0]    dead_band;
        logic [DRIVE_W-1:0] drive_floor;
        logic [CNT_W-1:0]   settle_ticks;
        logic               servo_on;
    } t_servo_settings;

    // What the block must return for one tick.
    typedef struct {
        logic [DRIVE_W-1:0] fwd_drive;
        logic [DRIVE_W-1:0] rev_drive;
        t_mode              loop_mode;
        logic               turn_dir;
        logic               drive_saturated;
    } t_drive_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [POS_W-1:0]     i_target_pos = '0;
    logic [POS_W-1:0]     i_measured_pos = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [DRIVE_W-1:0]   o_fwd_drive;
    logic [DRIVE_W-1:0]   o_rev_drive;
    logic [1:0]           o_loop_mode;
    logic                 o_turn_dir;
    logic                 o_drive_saturated;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_wdata = '0;

    servo_pid_position_controller dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_target_pos      (i_target_pos),
        .i_measured_pos    (i_measured_pos),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_fwd_drive       (o_fwd_drive),
        .o_rev_drive       (o_rev_drive),
        .o_loop_mode       (o_loop_mode),
        .o_turn_dir        (o_turn_dir),
        .o_drive_saturated (o_drive_saturated),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Scoreboard: predicted results in tick order, and the running error count.
    t_drive_result pending_drives[$];
    t_drive_result want;
    int            mismatch_count = 0;
    int            ticks_sent = 0;
    int            cycle_count = 0;

    // While calm is set neither side idles at random. A nonzero hold_request starts a
    // hold-off on the result side whose length is set by its value, counted in hold_left.
    bit            calm = 1'b0;
    int            hold_request = 0;
    int            hold_left = 0;

    // Predictor copy of the configuration, starting at the reset values.
    t_servo_settings cur = '{gain_p: 10'd100, gain_i: 10'd1, gain_d: 10'd100,
                             slew_step: 10'd20, dead_band: 9'd10, drive_floor: 10'd75,
                             settle_ticks: 8'd6, servo_on: 1'b1};

    // Predictor copy of the loop state, again at reset values.
    t_mode              servo_mode = MODE_START;
    logic               dir_now = 1'b0;
    logic               dir_before = 1'b0;
    logic               sat_flag = 1'b0;
    logic [CNT_W-1:0]   stop_cnt = COUNT_RESET;
    logic [CNT_W-1:0]   brake_cnt = COUNT_RESET;
    int                 cmd_pos = 0;
    logic [DRIVE_W-1:0] drive_lvl = '0;
    int                 err_sum = 0;
    int                 err_hist[HIST_DEPTH] = '{default: 0};
    int                 hist_ptr = 0;

    // Random idling, used by both sides: a chance of about 6 in a hundred per call.
    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 6);
    endfunction

    function automatic int clamp_pos(int pos);
        if (pos < 0) return 0;
        if (pos > 1023) return 1023;
        return pos;
    endfunction

    // One tick of the run state: deadband countdown, slew-limited command,
    // error history, integral and the clamped drive level.
    function automatic void run_loop_tick(int tgt, int meas, int distance);
        int     err;
        int     past;
        longint acc;
        longint pid;
        longint lvl;
        if (distance < int'(cur.dead_band)) begin
            if (brake_cnt != 0) brake_cnt--;
        end else begin
            brake_cnt = cur.settle_ticks;
        end
        if (brake_cnt == 0) begin
            servo_mode = MODE_BRAKE;
            return;
        end
        stop_cnt = cur.settle_ticks;

        // The command position walks toward the target without overshooting it.
        if (cmd_pos < tgt) begin
            cmd_pos += int'(cur.slew_step);
            if (cmd_pos > tgt) cmd_pos = tgt;
        end else if (cmd_pos > tgt) begin
            cmd_pos -= int'(cur.slew_step);
            if (cmd_pos < tgt) cmd_pos = tgt;
        end

        // The error is always the negative distance; only the direction carries a sign.
        err = 0;
        if (meas < cmd_pos) begin
            dir_now = 1'b0;
            err = meas - cmd_pos;
        end else if (meas > cmd_pos) begin
            dir_now = 1'b1;
            err = cmd_pos - meas;
        end

        // The slot after the newest one holds the error from five ticks back.
        if (hist_ptr >= HIST_DEPTH) hist_ptr = 0;
        err_hist[hist_ptr] = err;
        hist_ptr++;
        if (hist_ptr >= HIST_DEPTH) hist_ptr = 0;
        past = err_hist[hist_ptr];

        if (dir_before != dir_now) err_sum = 0;
        dir_before = dir_now;

        // The integral is frozen while the previous drive was saturated.
        if (!sat_flag) begin
            acc = longint'(err_sum) + longint'(err);
            if (acc < SUM_FLOOR) acc = SUM_FLOOR;
            err_sum = int'(acc);
        end

        pid = longint'(cur.gain_p) * longint'(err)
            + longint'(cur.gain_i) * longint'(err_sum)
            + longint'(cur.gain_d) * (longint'(err) - longint'(past));
        pid = pid / 100;
        lvl = longint'(cur.drive_floor) - pid;

        sat_flag = 1'b0;
        if (lvl < 0) begin
            lvl = 0;
        end else if (lvl > longint'(DRIVE_MAX)) begin
            lvl = longint'(DRIVE_MAX);
            sat_flag = 1'b1;
        end
        drive_lvl = DRIVE_W'(lvl);
    endfunction

    // Advances the predicted state by one accepted tick and returns its result.
    function automatic t_drive_result predict_drive(int tgt, int meas);
        t_drive_result res;
        int            distance;
        distance = (meas > tgt) ? meas - tgt : tgt - meas;
        res.fwd_drive = '0;
        res.rev_drive = '0;
        if (cur.servo_on) begin
            case (servo_mode)
                MODE_START: begin
                    dir_now = (tgt < meas) ? 1'b0 : 1'b1;
                    servo_mode = MODE_RUN;
                    err_sum = 0;
                    cmd_pos = meas;
                end
                MODE_BRAKE: begin
                    if (distance > 2 * int'(cur.dead_band)) begin
                        stop_cnt = cur.settle_ticks;
                        servo_mode = MODE_RUN;
                        run_loop_tick(tgt, meas, distance);
                    end else if (stop_cnt != 0) begin
                        stop_cnt--;
                    end else begin
                        drive_lvl = '0;
                        err_sum = 0;
                        servo_mode = MODE_STOP;
                    end
                end
                MODE_RUN: begin
                    run_loop_tick(tgt, meas, distance);
                end
                default: begin
                    // Leaving stop only changes the mode; the held drive is zero.
                    if (distance > int'(cur.dead_band)) servo_mode = MODE_RUN;
                    else drive_lvl = '0;
                    cmd_pos = meas;
                end
            endcase
            if (servo_mode == MODE_BRAKE) begin
                res.fwd_drive = DRIVE_MAX;
                res.rev_drive = DRIVE_MAX;
            end else if (servo_mode == MODE_RUN) begin
                if (dir_now == 1'b0) res.fwd_drive = drive_lvl;
                else res.rev_drive = drive_lvl;
            end
        end
        res.loop_mode = servo_mode;
        res.turn_dir = dir_now;
        res.drive_saturated = sat_flag;
        return res;
    endfunction

    // Sends one tick, idling at random first. Valid stays high on return so that
    // the next item can follow without a gap; wait_idle lowers it.
    task automatic send_item(int tgt, int meas);
        while (take_break()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_target_pos <= POS_W'(tgt);
        i_measured_pos <= POS_W'(meas);
        do @(posedge i_clk); while (o_stall);
        pending_drives.push_back(predict_drive(tgt, meas));
        ticks_sent++;
    endtask

    // Stops sending and waits until every predicted result has come back, plus a
    // few cycles for the three pipeline stages to empty.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes one register. The valid is only lowered after the last write of a
    // batch, so back-to-back writes never lower and raise it in the same step.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] data, bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_GAIN_P:       cur.gain_p = data;
            CFG_GAIN_I:       cur.gain_i = data;
            CFG_GAIN_D:       cur.gain_d = data;
            CFG_SLEW_STEP:    cur.slew_step = data;
            CFG_DEAD_BAND:    cur.dead_band = data[DB_W-1:0];
            CFG_DRIVE_FLOOR:  cur.drive_floor = data;
            CFG_SETTLE_TICKS: cur.settle_ticks = data[CNT_W-1:0];
            default:          cur.servo_on = data[0];
        endcase
        if (last) i_cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(t_servo_settings s);
        write_reg(CFG_GAIN_P, s.gain_p, 1'b0);
        write_reg(CFG_GAIN_I, s.gain_i, 1'b0);
        write_reg(CFG_GAIN_D, s.gain_d, 1'b0);
        write_reg(CFG_SLEW_STEP, s.slew_step, 1'b0);
        write_reg(CFG_DEAD_BAND, CFG_DAT_W'(s.dead_band), 1'b0);
        write_reg(CFG_DRIVE_FLOOR, s.drive_floor, 1'b0);
        write_reg(CFG_SETTLE_TICKS, CFG_DAT_W'(s.settle_ticks), 1'b0);
        write_reg(CFG_SERVO_ON, CFG_DAT_W'(s.servo_on), 1'b1);
    endtask

    // Walks the mode machine through start, run, brake, the return from brake to
    // run, stop and the return from stop, then shows the zero settle behavior.
    task automatic test_mode_walk();
        t_servo_settings s;
        s = cur;
        s.settle_ticks = 8'd1;
        load_settings(s);
        send_item(600, 200);   // start tick
        send_item(600, 200);
        send_item(600, 600);   // on target: brake
        send_item(600, 700);   // far off again: back to run in the same tick
        send_item(600, 600);
        send_item(600, 605);
        send_item(600, 600);   // countdown done: stop
        send_item(600, 605);
        send_item(600, 900);   // leaves stop, mode change only
        send_item(600, 900);
        wait_idle();
        write_reg(CFG_SETTLE_TICKS, '0, 1'b1);
        send_item(600, 300);   // with no settle time every run tick brakes
        send_item(600, 300);
        send_item(600, 600);
    endtask

    // Position extremes with the largest gains, which drive the level into saturation.
    task automatic test_field_extremes();
        wait_idle();
        load_settings('{gain_p: 10'd1023, gain_i: 10'd1023, gain_d: 10'd1023,
                        slew_step: 10'd1023, dead_band: 9'd0, drive_floor: 10'd1023,
                        settle_ticks: 8'd1, servo_on: 1'b1});
        send_item(0, 1023);
        send_item(1023, 0);
        send_item(0, 0);
        send_item(1023, 1023);
    endtask

    // A large error that vanishes at once gives a positive derivative term and a
    // drive below zero, which must clamp to zero and clear the saturation flag.
    task automatic test_negative_drive();
        int k;
        wait_idle();
        load_settings('{gain_p: 10'd0, gain_i: 10'd0, gain_d: 10'd1023,
                        slew_step: 10'd1023, dead_band: 9'd0, drive_floor: 10'd0,
                        settle_ticks: 8'd1, servo_on: 1'b1});
        for (k = 0; k < 5; k++) send_item(1023, 0);
        send_item(1023, 1023);
    endtask

    // With the loop switched off the state holds and both drives read zero.
    task automatic test_disabled();
        wait_idle();
        write_reg(CFG_SERVO_ON, '0, 1'b1);
        send_item(1023, 0);
        send_item(0, 1023);
        wait_idle();
        write_reg(CFG_SERVO_ON, CFG_DAT_W'(1), 1'b1);
    endtask

    // The result side holds off for a long stretch while ticks keep coming, so
    // the pipeline fills and the block must stall its input.
    task automatic test_backpressure();
        int k;
        wait_idle();
        calm = 1'b1;
        hold_request = 80;
        for (k = 0; k < 40; k++) send_item($urandom_range(1023), $urandom_range(1023));
        calm = 1'b0;
    endtask

    function automatic t_servo_settings random_settings(int phase);
        t_servo_settings s;
        if (phase == 0) begin
            s = '{gain_p: 10'd1023, gain_i: 10'd1023, gain_d: 10'd1023,
                  slew_step: 10'd1023, dead_band: 9'd511, drive_floor: 10'd1023,
                  settle_ticks: 8'd255, servo_on: 1'b1};
        end else if (phase == 1) begin
            s = '{gain_p: 10'd0, gain_i: 10'd0, gain_d: 10'd0, slew_step: 10'd1,
                  dead_band: 9'd0, drive_floor: 10'd0, settle_ticks: 8'd0, servo_on: 1'b1};
        end else begin
            s.gain_p = GAIN_W'(($urandom_range(2) == 0) ? $urandom_range(1023)
                                                        : $urandom_range(200));
            s.gain_i = GAIN_W'(($urandom_range(2) == 0) ? $urandom_range(1023)
                                                        : $urandom_range(20));
            s.gain_d = GAIN_W'(($urandom_range(2) == 0) ? $urandom_range(1023)
                                                        : $urandom_range(200));
            s.slew_step = POS_W'(($urandom_range(3) == 0) ? $urandom_range(1023, 1)
                                                          : $urandom_range(60, 1));
            s.dead_band = DB_W'(($urandom_range(3) == 0) ? $urandom_range(511)
                                                         : $urandom_range(40, 1));
            s.drive_floor = DRIVE_W'($urandom_range(1023));
            s.settle_ticks = CNT_W'(($urandom_range(4) == 0) ? $urandom_range(255)
                                                             : $urandom_range(8));
            s.servo_on = ($urandom_range(7) != 0);
        end
        return s;
    endfunction

    // A plausible move: the measured position closes in on a target, then sits
    // near it long enough to brake and stop, with an occasional kick out of band.
    task automatic send_move();
        int tgt;
        int meas;
        int stride;
        int dwell;
        int span;
        int off;
        int k;
        tgt = $urandom_range(1023);
        meas = $urandom_range(1023);
        stride = $urandom_range(80, 1);
        for (k = 0; k < 15 && meas != tgt; k++) begin
            if (meas < tgt) meas = (tgt - meas > stride) ? meas + stride : tgt;
            else meas = (meas - tgt > stride) ? meas - stride : tgt;
            send_item(tgt, meas);
        end
        dwell = $urandom_range(20);
        span = int'(cur.dead_band);
        for (k = 0; k < dwell; k++) begin
            if ($urandom_range(9) == 0) off = $urandom_range(3 * span + 2);
            else off = (span == 0) ? 0 : $urandom_range(span - 1);
            if ($urandom_range(1) == 1) off = -off;
            send_item(tgt, clamp_pos(tgt + off));
        end
    endtask

    // Twelve settings, the two extremes first, each with about 95 ticks of mostly
    // well-formed moves and some unrelated noise. Two phases run without idling.
    task automatic test_random_phases();
        int phase;
        int phase_end;
        for (phase = 0; phase < 12; phase++) begin
            wait_idle();
            load_settings(random_settings(phase));
            calm = (phase == 4 || phase == 5);
            phase_end = ticks_sent + 95;
            while (ticks_sent < phase_end) begin
                if ($urandom_range(3) != 0) send_move();
                else send_item($urandom_range(1023), $urandom_range(1023));
            end
        end
        calm = 1'b0;
    endtask

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
            i_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= take_break();
        end
    end

    task automatic check_field(string name, int expv, int actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
            mismatch_count++;
        end
    endtask

    // Every accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_drives.size() == 0) begin
                $error("Result with no tick outstanding: fwd %0d rev %0d mode %0d",
                       o_fwd_drive, o_rev_drive, o_loop_mode);
                mismatch_count++;
            end else begin
                want = pending_drives.pop_front();
                check_field("fwd_drive", int'(want.fwd_drive), int'(o_fwd_drive));
                check_field("rev_drive", int'(want.rev_drive), int'(o_rev_drive));
                check_field("loop_mode", int'(want.loop_mode), int'(o_loop_mode));
                check_field("turn_dir", int'(want.turn_dir), int'(o_turn_dir));
                check_field("drive_saturated", int'(want.drive_saturated),
                            int'(o_drive_saturated));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_drives.size());
        $display("Regression FAIL");
        $finish;
    end

    // Test sequence: reset once, the directed checks, the full pipeline case, then
    // the random phases, and a final drain before the verdict.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_mode_walk();
        test_field_extremes();
        test_negative_drive();
        test_disabled();
        test_backpressure();
        test_random_phases();
        wait_idle();
        if (pending_drives.size() != 0) begin
            $error("%0d predicted results never arrived", pending_drives.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
